@@ design/mdv_pkg.sv @@
// ----------------------------------------------------------------------------
// mdv_pkg : shared constants for the modulated delay vibrato
// Register codes, unity values of the fixed-point formats, queue depth.
// ----------------------------------------------------------------------------
`default_nettype none

package mdv_pkg;

    // default length of the delay store
    localparam int DELAY_DEPTH_DEF = 1024;

    // depth of the queues between front, back and result side
    localparam int QUEUE_DEPTH = 4;

    // configuration register codes
    localparam logic CFG_MIX_DEPTH       = 1'b0;
    localparam logic CFG_SWEEP_INTENSITY = 1'b1;

    // unity in Q1.15 and Q1.16
    localparam logic [15:0] WET_ONE   = 16'd32768;
    localparam logic [16:0] INTEN_ONE = 17'd65536;

    // one slew step of the sweep multiplier (one in 16 fraction bits)
    localparam int SLEW_STEP = 65536;

    // sweep multiplier at full intensity: (depth - 2) / 2 with 16 fraction bits
    function automatic longint sweep_full(input int depth);
        return (longint'(depth) - 64'sd2) * 64'sd32768;
    endfunction

endpackage

`default_nettype wire

@@ design/modulated_delay_vibrato.sv @@
// ----------------------------------------------------------------------------
// modulated_delay_vibrato : vibrato by a modulated delay line
// Push a sample with its modulation value and block-start mark while full is
// low; each sample yields one mixed sample, taken by pop while empty is low.
// Configuration: i_cfg_valid with index and data; o_cfg_ready is always high
// and a write takes effect on the next cycle. Write only while idle.
// Path: front stages A and B, middle queue, back stages C and D, result queue.
// Throughput: one sample per cycle sustained while the receiver keeps up, set by
// the single write and single read of the delay store in the back end per sample.
// Reset: the store reads as zero until written (a wrap flag, no clear pass),
// the write pointer is zero, depth and intensity are at one.
// A stalled receiver fills the result queue; the back end then stops taking
// work, the middle queue fills and full rises. Nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module modulated_delay_vibrato #(
    parameter int DELAY_DEPTH = mdv_pkg::DELAY_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] i_dry_sample,
    input  wire logic signed [15:0] i_mod_value,
    input  wire logic               i_block_start,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [15:0]      o_wet_sample,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [16:0]        i_cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int CW = AW + 15;
    localparam logic [CW-1:0] TGT_RST = CW'(mdv_pkg::sweep_full(DELAY_DEPTH));
    localparam logic [AW-1:0] DM2     = AW'(DELAY_DEPTH - 2);

    // configuration: hold the clamped wet share and the derived sweep target
    logic [15:0]     r_wet;
    logic [CW-1:0]   r_target;
    logic            cfg_wr;
    logic [16:0]     inten;
    logic [AW+16:0]  tprod;
    logic [15:0]     wet_new;

    // front to back queue
    logic                 f_push;
    logic signed [15:0]   f_dry;
    logic [AW-1:0]        f_delay;
    logic                 mid_full, mid_empty, mid_pop;
    logic [AW+15:0]       mid_data;

    // back to result queue
    logic                 b_push;
    logic signed [15:0]   b_result;
    logic                 out_full;
    logic                 out_pop;
    logic [15:0]          out_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // clamp above one
    assign inten   = (i_cfg_data > mdv_pkg::INTEN_ONE) ? mdv_pkg::INTEN_ONE : i_cfg_data;
    assign wet_new = (i_cfg_data[15:0] > mdv_pkg::WET_ONE) ? mdv_pkg::WET_ONE
                                                           : i_cfg_data[15:0];
    // target = (depth - 2) * intensity / 2
    assign tprod   = (AW + 17)'(DM2) * (AW + 17)'(inten);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet    <= mdv_pkg::WET_ONE;
            r_target <= TGT_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                mdv_pkg::CFG_MIX_DEPTH: begin
                    r_wet <= wet_new;
                end
                mdv_pkg::CFG_SWEEP_INTENSITY: begin
                    r_target <= tprod[AW+15:1];
                end
                default: begin
                    r_wet <= r_wet;
                end
            endcase
        end
    end

    mdv_front #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_dry_sample  (i_dry_sample),
        .i_mod_value   (i_mod_value),
        .i_block_start (i_block_start),
        .i_target      (r_target),
        .o_push        (f_push),
        .o_dry         (f_dry),
        .o_delay       (f_delay),
        .i_drain       (mid_pop)
    );

    mdv_fifo #(
        .WIDTH (AW + 16),
        .DEPTH (mdv_pkg::QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_dry, f_delay}),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    mdv_back #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!mid_empty),
        .i_dry     ($signed(mid_data[AW+15:AW])),
        .i_delay   (mid_data[AW-1:0]),
        .o_take    (mid_pop),
        .i_wet     (r_wet),
        .o_push    (b_push),
        .o_result  (b_result),
        .i_out_pop (out_pop)
    );

    assign out_pop = pop && !empty;

    mdv_fifo #(
        .WIDTH (16),
        .DEPTH (mdv_pkg::QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  (b_result),
        .o_full  (out_full),
        .i_pop   (out_pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign o_wet_sample = $signed(out_data);

    // credit in the front end must keep the middle queue from overflowing
    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !mid_full)
        else $error("middle queue pushed while full");

    // credit in the back end must keep the result queue from overflowing
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_push |-> !out_full)
        else $error("result queue pushed while full");

    // the back end takes work only when the middle queue holds some
    a_take_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_pop |-> !mid_empty)
        else $error("back end took from an empty queue");

    // reset drops every result in flight
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("results visible after reset");

endmodule

`default_nettype wire

@@ design/mdv_fifo.sv @@
// ----------------------------------------------------------------------------
// mdv_fifo : small first-in first-out queue
// Register-based queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mdv_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = mdv_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    assign wr_en = i_push && !o_full;
    assign rd_en = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (wr_en) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        n_cnt = r_cnt + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ design/mdv_front.sv @@
// ----------------------------------------------------------------------------
// mdv_front : intake, sweep slew and delay computation
// Accepts samples, slews the sweep multiplier on block start and turns the
// modulation value into an integer delay for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mdv_front #(
    parameter int DELAY_DEPTH = mdv_pkg::DELAY_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire logic signed [15:0]             i_dry_sample,
    input  wire logic signed [15:0]             i_mod_value,
    input  wire logic                           i_block_start,
    input  wire logic [$clog2(DELAY_DEPTH)+14:0] i_target,
    output logic                                o_push,
    output logic signed [15:0]                  o_dry,
    output logic [$clog2(DELAY_DEPTH)-1:0]      o_delay,
    input  wire logic                           i_drain
);

    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int CW  = AW + 15;
    localparam int QCW = $clog2(mdv_pkg::QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] CUR_RST = CW'(mdv_pkg::sweep_full(DELAY_DEPTH));

    logic                 accept;
    logic [QCW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]        r_cur, n_cur;
    logic [CW:0]          cur_x, tgt_x, step_x;
    logic                 r_a_valid;
    logic signed [15:0]   r_a_dry;
    logic [15:0]          r_a_moff;
    logic                 r_b_valid;
    logic signed [15:0]   r_b_dry;
    logic [AW-1:0]        r_b_delay;
    logic [CW+15:0]       prod;

    // credit covers both stages and the queue behind them
    assign o_full = (r_cnt == QCW'(mdv_pkg::QUEUE_DEPTH));
    assign accept = i_push && !o_full;
    assign n_cnt  = r_cnt + QCW'(accept) - QCW'(i_drain);

    // slew one step toward the target; a step down that lands below it is undone
    assign cur_x  = {1'b0, r_cur};
    assign tgt_x  = {1'b0, i_target};
    assign step_x = (CW + 1)'(mdv_pkg::SLEW_STEP);

    always_comb begin
        n_cur = r_cur;
        if (accept && i_block_start) begin
            if (cur_x > tgt_x) begin
                if (cur_x >= tgt_x + step_x) begin
                    n_cur = CW'(cur_x - step_x);
                end
            end else if (cur_x < tgt_x) begin
                n_cur = CW'(cur_x + step_x);
            end
        end
    end

    // r_cur holds this item's multiplier while it sits in stage A
    assign prod = (CW + 16)'(r_cur) * (CW + 16)'(r_a_moff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cur     <= CUR_RST;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_cur     <= n_cur;
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_dry  <= i_dry_sample;
            r_a_moff <= {~i_mod_value[15], i_mod_value[14:0]};
        end
        if (r_a_valid) begin
            r_b_dry   <= r_a_dry;
            r_b_delay <= prod[CW+15:31];
        end
    end

    assign o_push  = r_b_valid;
    assign o_dry   = r_b_dry;
    assign o_delay = r_b_delay;

endmodule

`default_nettype wire

@@ design/mdv_back.sv @@
// ----------------------------------------------------------------------------
// mdv_back : delay store access and wet/dry mix
// Writes each sample into the circular store, reads the delayed one and
// mixes, rounds and saturates the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mdv_back #(
    parameter int DELAY_DEPTH = mdv_pkg::DELAY_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic signed [15:0]             i_dry,
    input  wire logic [$clog2(DELAY_DEPTH)-1:0] i_delay,
    output logic                                o_take,
    input  wire logic [15:0]                    i_wet,
    output logic                                o_push,
    output logic signed [15:0]                  o_result,
    input  wire logic                           i_out_pop
);

    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int QCW = $clog2(mdv_pkg::QUEUE_DEPTH + 1);

    logic [15:0]          r_mem [DELAY_DEPTH];
    logic [AW-1:0]        r_wp, n_wp;
    logic                 r_wrapped, n_wrapped;
    logic [QCW-1:0]       r_cnt, n_cnt;
    logic [AW:0]          diff;
    logic [AW-1:0]        rd;

    logic                 r_c_valid;
    logic signed [15:0]   r_c_dry;
    logic [15:0]          r_c_rdata;
    logic                 r_c_bypass;
    logic                 r_c_blank;
    logic signed [15:0]   delayed;

    logic                 r_d_valid;
    logic signed [32:0]   r_d_pw;
    logic signed [32:0]   r_d_pd;
    logic signed [16:0]   wet_s, dryw_s;
    logic signed [32:0]   acc, res;

    // credit covers both stages and the result queue
    assign o_take = i_valid && (r_cnt < QCW'(mdv_pkg::QUEUE_DEPTH));
    assign n_cnt  = r_cnt + QCW'(o_take) - QCW'(i_out_pop);

    // read index wraps below zero
    assign diff = {1'b0, r_wp} - {1'b0, i_delay};
    assign rd   = diff[AW] ? AW'(diff + (AW + 1)'(DELAY_DEPTH)) : diff[AW-1:0];

    always_comb begin
        n_wp      = r_wp;
        n_wrapped = r_wrapped;
        if (o_take) begin
            if (r_wp == AW'(DELAY_DEPTH - 1)) begin
                n_wp      = '0;
                n_wrapped = 1'b1;
            end else begin
                n_wp = r_wp + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_cnt     <= '0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_wp      <= n_wp;
            r_wrapped <= n_wrapped;
            r_cnt     <= n_cnt;
            r_c_valid <= o_take;
            r_d_valid <= r_c_valid;
        end
    end

    // store access: one write and one registered read per sample
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_mem[r_wp] <= i_dry;
            r_c_rdata   <= r_mem[rd];
            r_c_dry     <= i_dry;
            r_c_bypass  <= (i_delay == '0);
            // before the first wrap, entries above the write pointer read as zero
            r_c_blank   <= !r_wrapped && diff[AW];
        end
    end

    always_comb begin
        if (r_c_bypass) begin
            delayed = r_c_dry;
        end else if (r_c_blank) begin
            delayed = '0;
        end else begin
            delayed = $signed(r_c_rdata);
        end
    end

    assign wet_s  = $signed({1'b0, i_wet});
    assign dryw_s = $signed({1'b0, mdv_pkg::WET_ONE} - {1'b0, i_wet});

    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            r_d_pw <= 33'(wet_s) * 33'(delayed);
            r_d_pd <= 33'(dryw_s) * 33'(r_c_dry);
        end
    end

    // round half up, floor shift, saturate
    assign acc = r_d_pw + r_d_pd;
    assign res = (acc + 33'sd16384) >>> 15;

    always_comb begin
        if (res > 33'sd32767) begin
            o_result = 16'sh7fff;
        end else if (res < -33'sd32768) begin
            o_result = -16'sh8000;
        end else begin
            o_result = res[15:0];
        end
    end

    assign o_push = r_d_valid;

endmodule

`default_nettype wire
